/* rtl/bcc_pkg.sv */
// Shared types and constants for the barometer calibration compensation block.
// No dependencies; used by every module in rtl/.
`default_nettype none

package bcc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CAL_WORD_A = 2'd0,
    CAL_WORD_B = 2'd1,
    CAL_WORD_C = 2'd2,
    CAL_WORD_D = 2'd3
  } cfg_index_t;

  // Coefficients unpacked from the calibration words.
  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
  } coef_t;

  // Beat leaving the front half of the pipeline.
  typedef struct packed {
    logic               valid;
    logic signed [18:0] sens;
    logic signed [16:0] d1m;
    logic signed [17:0] off;
    logic signed [13:0] temp;
  } mid_t;

  localparam logic [16:0] DT_BASE     = 17'd20224;
  localparam logic [16:0] D1_BASE     = 17'd7168;
  localparam logic [15:0] SENS_BASE   = 16'd24576;
  localparam logic [10:0] C4_BASE     = 11'd512;
  localparam logic [7:0]  C6_BIAS     = 8'd50;
  localparam logic [17:0] PRESS_BASE  = 18'd2500;
  localparam logic [15:0] TEMP_BASE   = 16'd200;

endpackage

`default_nettype wire

/* rtl/bcc_coef.sv */
// Calibration word registers and their unpacking into coefficients C1..C6.
// Depends on bcc_pkg.
`default_nettype none

module bcc_coef (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire bcc_pkg::cfg_index_t cfg_index,
  input  wire logic [15:0]         cfg_data,
  output bcc_pkg::coef_t           coef
);
  import bcc_pkg::*;

  logic [15:0] word_a, word_b, word_c, word_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= '0;
      word_b <= '0;
      word_c <= '0;
      word_d <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CAL_WORD_A: word_a <= cfg_data;
        CAL_WORD_B: word_b <= cfg_data;
        CAL_WORD_C: word_c <= cfg_data;
        CAL_WORD_D: word_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.c1 = word_a[15:1];
    coef.c2 = {word_c[5:0], word_d[5:0]};
    coef.c3 = word_d[15:6];
    coef.c4 = word_c[15:6];
    coef.c5 = {word_a[0], word_b[15:6]};
    coef.c6 = word_b[5:0];
  end

endmodule

`default_nettype wire

/* rtl/bcc_front.sv */
// Front half of the compensation pipeline: dt, the three dt products, then
// offset, sensitivity and temperature. Depends on bcc_pkg.
`default_nettype none

module bcc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [15:0]    raw_pressure,
  input  wire logic [15:0]    raw_temperature,
  input  wire bcc_pkg::coef_t coef,
  output bcc_pkg::mid_t       mid
);
  import bcc_pkg::*;

  // stage 1
  logic               s1_valid;
  logic signed [16:0] s1_dt;
  logic signed [16:0] s1_d1m;
  // stage 2
  logic               s2_valid;
  logic signed [27:0] s2_off_prod;
  logic signed [27:0] s2_sens_prod;
  logic signed [24:0] s2_temp_prod;
  logic signed [16:0] s2_d1m;

  logic signed [10:0] c4m;
  logic signed [10:0] c3s;
  logic signed [7:0]  c6p;
  logic [15:0]        sens_base;
  logic [15:0]        temp_sum;

  assign c4m       = signed'({1'b0, coef.c4} - C4_BASE);
  assign c3s       = signed'({1'b0, coef.c3});
  assign c6p       = signed'({2'b00, coef.c6} + C6_BIAS);
  assign sens_base = {1'b0, coef.c1} + SENS_BASE;
  assign temp_sum  = {s2_temp_prod[24], s2_temp_prod[24:10]} + TEMP_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      s1_valid  <= start;
      s2_valid  <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_dt  <= signed'({1'b0, raw_temperature} - {3'b000, coef.c5, 3'b000} - DT_BASE);
    s1_d1m <= signed'({1'b0, raw_pressure} - D1_BASE);

    s2_off_prod  <= s1_dt * c4m;
    s2_sens_prod <= s1_dt * c3s;
    s2_temp_prod <= s1_dt * c6p;
    s2_d1m       <= s1_d1m;

    // the whole mid beat is written here, valid bit included
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= s2_valid;
    end

    // floor shifts are arithmetic part-selects of the products
    mid.off  <= signed'({4'b0000, coef.c2, 2'b00}
                        + {{2{s2_off_prod[27]}}, s2_off_prod[27:12]});
    mid.sens <= signed'({3'b000, sens_base} + {s2_sens_prod[27], s2_sens_prod[27:10]});
    mid.temp <= signed'(temp_sum[13:0]);
    mid.d1m  <= s2_d1m;
  end

endmodule

`default_nettype wire

/* rtl/bcc_back.sv */
// Back half of the compensation pipeline: sens * (D1 - 7168), x, and the
// registered pressure and temperature outputs. Depends on bcc_pkg.
`default_nettype none

module bcc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bcc_pkg::mid_t mid,
  output logic               done,
  output logic signed [17:0] pressure_tenths_mbar,
  output logic signed [13:0] temperature_tenths_c
);
  import bcc_pkg::*;

  // stage 4
  logic               s4_valid;
  logic signed [35:0] s4_prod;
  logic signed [17:0] s4_off;
  logic signed [13:0] s4_temp;
  // stage 5
  logic               s5_valid;
  logic signed [22:0] s5_x;
  logic signed [13:0] s5_temp;

  logic [26:0] x_times10;

  // 10 * x as 8x + 2x
  assign x_times10 = {s5_x[22], s5_x, 3'b000} + {{3{s5_x[22]}}, s5_x, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s4_valid <= mid.valid;
      s5_valid <= s4_valid;
      done     <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_prod <= mid.sens * mid.d1m;
    s4_off  <= mid.off;
    s4_temp <= mid.temp;

    s5_x    <= signed'({s4_prod[35], s4_prod[35:14]} - {{5{s4_off[17]}}, s4_off});
    s5_temp <= s4_temp;

    pressure_tenths_mbar <= signed'(x_times10[22:5] + PRESS_BASE);
    temperature_tenths_c <= s5_temp;
  end

endmodule

`default_nettype wire

/* rtl/barometer_calibration_compensation.sv */
// Barometer first-order calibration compensation, six-stage pipeline.
// A beat taken with start passes through s1, s2, mid, s4 and s5 and leaves with done
// high on the registered outputs. Throughput: one beat per clock; busy stays low,
// as the multipliers are pipelined (three on dt, one on sens * (D1 - 7168)).
// Reset (rst, synchronous) clears the calibration words and all valid bits;
// the receiver cannot stall, so done is a one-cycle strobe.
`default_nettype none

module barometer_calibration_compensation (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [15:0]         raw_pressure,
  input  wire logic [15:0]         raw_temperature,
  output logic                     done,
  output logic signed [17:0]       pressure_tenths_mbar,
  output logic signed [13:0]       temperature_tenths_c,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire bcc_pkg::cfg_index_t cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import bcc_pkg::*;

  coef_t coef;
  mid_t  mid;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  bcc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  bcc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .coef            (coef),
    .mid             (mid)
  );

  bcc_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .mid                  (mid),
    .done                 (done),
    .pressure_tenths_mbar (pressure_tenths_mbar),
    .temperature_tenths_c (temperature_tenths_c)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for barometer_calibration_compensation: directed and random
// calibration words and raw samples, predicted in SystemVerilog and checked per beat.
// Depends on rtl/bcc_pkg.sv and rtl/barometer_calibration_compensation.sv.
`timescale 1ns / 100ps

module testbench;
  import bcc_pkg::*;

  localparam int LATENCY = 6;

  typedef struct {
    logic signed [17:0] pressure;
    logic signed [13:0] temperature;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] raw_pressure = '0;
  logic [15:0] raw_temperature = '0;
  logic cfg_valid = 1'b0;
  cfg_index_t cfg_index = CAL_WORD_A;
  logic [15:0] cfg_data = '0;
  logic busy;
  logic done;
  logic cfg_ready;
  logic signed [17:0] pressure_tenths_mbar;
  logic signed [13:0] temperature_tenths_c;

  logic [15:0] cal_words [4] = '{default: 16'h0000};
  cfg_index_t cal_order [4] = '{CAL_WORD_A, CAL_WORD_B, CAL_WORD_C, CAL_WORD_D};
  reading_t expected_readings [$];
  int fail_count = 0;
  int max_gap = 3;

  barometer_calibration_compensation dut (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .raw_pressure         (raw_pressure),
    .raw_temperature      (raw_temperature),
    .done                 (done),
    .pressure_tenths_mbar (pressure_tenths_mbar),
    .temperature_tenths_c (temperature_tenths_c),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compensated pressure and temperature for one raw sample under the current words.
  function automatic reading_t compensate_reading(logic [15:0] d1_raw, logic [15:0] d2_raw);
    coef_t k;
    longint c1, c2, c3, c4, c5, c6, d1, d2, dt, offset, sens, x, press, temp;
    reading_t r;
    k.c1 = cal_words[CAL_WORD_A][15:1];
    k.c2 = {cal_words[CAL_WORD_C][5:0], cal_words[CAL_WORD_D][5:0]};
    k.c3 = cal_words[CAL_WORD_D][15:6];
    k.c4 = cal_words[CAL_WORD_C][15:6];
    k.c5 = {cal_words[CAL_WORD_A][0], cal_words[CAL_WORD_B][15:6]};
    k.c6 = cal_words[CAL_WORD_B][5:0];
    c1 = k.c1;
    c2 = k.c2;
    c3 = k.c3;
    c4 = k.c4;
    c5 = k.c5;
    c6 = k.c6;
    d1 = d1_raw;
    d2 = d2_raw;
    // arithmetic shifts on signed longint floor toward minus infinity
    dt = d2 - (8 * c5 + 20224);
    offset = 4 * c2 + (((c4 - 512) * dt) >>> 12);
    sens = 24576 + c1 + ((c3 * dt) >>> 10);
    x = ((sens * (d1 - 7168)) >>> 14) - offset;
    press = 2500 + ((10 * x) >>> 5);
    temp = 200 + ((dt * (c6 + 50)) >>> 10);
    r.pressure = press[17:0];
    r.temperature = temp[13:0];
    return r;
  endfunction

  // Send one sample; start stays high across back-to-back beats.
  task automatic send_reading(input logic [15:0] p, input logic [15:0] t);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    raw_pressure <= p;
    raw_temperature <= t;
    do @(posedge clk); while (busy);
    expected_readings.push_back(compensate_reading(p, t));
  endtask

  // Hold off new samples until every pending result has been checked.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_calibration(input logic [15:0] wa, input logic [15:0] wb,
                                  input logic [15:0] wc, input logic [15:0] wd);
    logic [15:0] w [4];
    w = '{wa, wb, wc, wd};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cal_order[i];
      cfg_data <= w[i];
      do @(posedge clk); while (!cfg_ready);
      cal_words[cal_order[i]] = w[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_calibration();
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hFFFF, 16'h0000);
  endtask

  task automatic test_extreme_calibration();
    drain_pipeline();
    load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'hFFFF);
    send_reading(16'hFFFF, 16'h0000);
    drain_pipeline();
    load_calibration(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_reading(16'd7168, 16'h8000);
    send_reading(16'hFFFF, 16'h0000);
    drain_pipeline();
    load_calibration(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_reading(16'd7168, 16'h8000);
    send_reading(16'h0000, 16'hFFFF);
  endtask

  // dt of zero, dt of minus one (flooring) and plus one, and D1 at and beside its base
  task automatic test_typical_calibration();
    int base;
    drain_pipeline();
    load_calibration(16'h9A7B, 16'h4B62, 16'hB3C9, 16'h9E51);
    base = 8 * {cal_words[CAL_WORD_A][0], cal_words[CAL_WORD_B][15:6]} + 20224;
    send_reading(16'd7168, 16'(base));
    send_reading(16'd7167, 16'(base - 1));
    send_reading(16'd7169, 16'(base + 1));
    send_reading(16'd16000, 16'd27000);
    send_reading(16'h0000, 16'(base));
  endtask

  task automatic test_random_samples();
    logic [15:0] w [4];
    logic [15:0] p, t;
    int base;
    for (int phase = 0; phase < 11; phase++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0: w[i] = 16'h0000;
          1: w[i] = 16'hFFFF;
          default: w[i] = 16'($urandom());
        endcase
      end
      drain_pipeline();
      load_calibration(w[0], w[1], w[2], w[3]);
      max_gap = (phase % 4 == 3) ? 0 : 3;
      base = 8 * {cal_words[CAL_WORD_A][0], cal_words[CAL_WORD_B][15:6]} + 20224;
      for (int n = 0; n < 50; n++) begin
        p = 16'($urandom());
        t = 16'($urandom());
        case ($urandom_range(0, 9))
          7: p = 16'(7168 + $urandom_range(0, 8) - 4);
          8: t = 16'(base + $urandom_range(0, 8) - 4);
          9: begin
            p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
          default: ;
        endcase
        send_reading(p, t);
      end
    end
    max_gap = 3;
  endtask

  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && done) begin
      if (expected_readings.size() == 0) begin
        $error("result with none pending: pressure %0d temperature %0d",
               pressure_tenths_mbar, temperature_tenths_c);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (pressure_tenths_mbar !== want.pressure) begin
          $error("pressure_tenths_mbar: expected %0d, got %0d",
                 want.pressure, pressure_tenths_mbar);
          fail_count++;
        end
        if (temperature_tenths_c !== want.temperature) begin
          $error("temperature_tenths_c: expected %0d, got %0d",
                 want.temperature, temperature_tenths_c);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_calibration();
    test_extreme_calibration();
    test_typical_calibration();
    test_random_samples();
    drain_pipeline();
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
